@@ src/sma_pkg.sv @@
`default_nettype none
package sma_pkg;

   localparam int DATA_W      = 64;
   localparam int CMD_W       = 5;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_W     = 9;
   localparam int STACK_DEPTH_DEFAULT = 256;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 5'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 5'd1;
   localparam logic [CMD_W-1:0] CMD_SUB   = 5'd2;
   localparam logic [CMD_W-1:0] CMD_MUL   = 5'd3;
   localparam logic [CMD_W-1:0] CMD_DIV   = 5'd4;
   localparam logic [CMD_W-1:0] CMD_SHL   = 5'd5;
   localparam logic [CMD_W-1:0] CMD_SHR   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_EQ    = 5'd7;
   localparam logic [CMD_W-1:0] CMD_NE    = 5'd8;
   localparam logic [CMD_W-1:0] CMD_LT    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_GT    = 5'd10;
   localparam logic [CMD_W-1:0] CMD_LE    = 5'd11;
   localparam logic [CMD_W-1:0] CMD_GE    = 5'd12;
   localparam logic [CMD_W-1:0] CMD_DUP   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_DROP  = 5'd14;
   localparam logic [CMD_W-1:0] CMD_SWAP  = 5'd15;
   localparam logic [CMD_W-1:0] CMD_NIP   = 5'd16;
   localparam logic [CMD_W-1:0] CMD_TUCK  = 5'd17;
   localparam logic [CMD_W-1:0] CMD_OVER  = 5'd18;
   localparam logic [CMD_W-1:0] CMD_ROT   = 5'd19;
   localparam logic [CMD_W-1:0] CMD_NROT  = 5'd20;
   localparam logic [CMD_W-1:0] CMD_PICK  = 5'd21;
   localparam logic [CMD_W-1:0] CMD_POP   = 5'd22;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

   typedef struct packed {
      logic start;
      logic is_div;
   } md_ctl_type;

   function automatic logic [1:0] need_of(input logic [CMD_W-1:0] cmd);
      logic [1:0] n;
      n = 2'd0;
      case (cmd) inside
         [CMD_ADD:CMD_GE]:                  n = 2'd2;
         CMD_DUP, CMD_DROP, CMD_PICK, CMD_POP: n = 2'd1;
         CMD_SWAP, CMD_NIP, CMD_TUCK, CMD_OVER: n = 2'd2;
         CMD_ROT, CMD_NROT:                 n = 2'd3;
         default:                           n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic grows(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_PUSH) || (cmd == CMD_DUP) || (cmd == CMD_TUCK) || (cmd == CMD_OVER);
   endfunction

endpackage
`default_nettype wire

@@ src/sma_muldiv.sv @@
`default_nettype none
module sma_muldiv
   import sma_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire md_ctl_type        ctl,
   input  wire logic [DATA_W-1:0] l,
   input  wire logic [DATA_W-1:0] r,
   output logic                   done,
   output logic [DATA_W-1:0]      result
);
   localparam int HALF = DATA_W / 2;
   localparam int SW = $clog2(DATA_W);

   logic              active_ff, active_in;
   logic              div_ff, div_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [DATA_W-1:0] l_ff, l_in, r_ff, r_in;
   logic [DATA_W-1:0] acc_ff, acc_in, prod_ff, prod_in;
   logic [DATA_W-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [HALF-1:0]   ma, mb;
   logic [DATA_W:0]   rem_sh, diff;

   // pick the partial product for this step; only the low word is kept
   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin ma = l_ff[HALF-1:0];      mb = r_ff[HALF-1:0];      end
         2'd1:    begin ma = l_ff[HALF-1:0];      mb = r_ff[DATA_W-1:HALF]; end
         default: begin ma = l_ff[DATA_W-1:HALF]; mb = r_ff[HALF-1:0];      end
      endcase
      prod_in = ma * mb;
      rem_sh  = {rem_ff, quo_ff[DATA_W-1]};
      diff    = rem_sh - {1'b0, r_ff};
   end

   always_comb begin
      active_in = active_ff;
      div_in    = div_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (ctl.start) begin
         active_in = 1'b1;
         div_in    = ctl.is_div;
         step_in   = '0;
         l_in      = l;
         r_in      = r;
         acc_in    = '0;
         quo_in    = l;
         rem_in    = '0;
      end else if (active_ff) begin
         step_in = step_ff + SW'(1);
         if (div_ff) begin
            // restoring step: shift in one dividend bit, subtract when it fits
            if (!diff[DATA_W]) begin
               rem_in = diff[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            if (step_ff == SW'(DATA_W - 1)) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end else begin
            case (step_ff[1:0])
               2'd0:    acc_in = acc_ff;
               2'd1:    acc_in = prod_ff;
               default: acc_in = acc_ff + {prod_ff[HALF-1:0], {HALF{1'b0}}};
            endcase
            if (step_ff[1:0] == 2'd3) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      div_ff  <= div_in;
      step_ff <= step_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? quo_ff : acc_ff;
endmodule
`default_nettype wire

@@ src/stack_machine_alu.sv @@
`default_nettype none
// Forth-style data-stack unit. A command transfers in at a rising edge with
// start high and busy low; its single result shows on the rsp_ ports for one
// cycle with rsp_valid high and must be taken then, as the receiver cannot
// stall. busy stays high from the transfer until the cycle after the strobe.
// An error goes straight to the result; other commands pass through the
// read states (skipped by push, dup, nip and unused codes), then execute,
// where mul and div wait for the muldiv unit, then the write-back states.
// Command timing is set by the stack memory (registered read, one write a
// cycle), by the 32x32 multiplier reused over three partial products and by
// the one-bit-a-cycle divider. The top entry lives in a register; the memory
// holds the entries below it, so no clearing pass is needed after reset.
module stack_machine_alu
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [DATA_W-1:0]   req_push_value,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [DATA_W-1:0]        rsp_top_value,
   output logic [DEPTH_W-1:0]       rsp_depth
);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RD0  = 8'b0000_0010,
      S_RD1  = 8'b0000_0100,
      S_CAP  = 8'b0000_1000,
      S_EXEC = 8'b0001_0000,
      S_WR0  = 8'b0010_0000,
      S_WR1  = 8'b0100_0000,
      S_RESP = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [DATA_W-1:0] imm_ff;
   logic [AW-1:0]     ra0_ff, ra1_ff, ra;
   logic [DATA_W-1:0] a0_ff, a1_ff, rd_ff;
   logic              md_go_ff, md_go_in;
   logic              w0_en_ff, w1_en_ff, w0_en, w1_en;
   logic [AW-1:0]     w0_addr_ff, w1_addr_ff, w0_addr, w1_addr;
   logic [DATA_W-1:0] w0_data_ff, w1_data_ff, w0_data, w1_data;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic              we;
   logic [AW-1:0]     wa;
   logic [DATA_W-1:0] wd;

   logic              accept, is_md, no_read, is_rot;
   logic [STATUS_W-1:0] err;
   logic [CW-1:0]     c1, c2, c3, cpick;
   logic [DATA_W-1:0] alu, x_tos, x_top;
   logic [CW-1:0]     x_cnt;
   md_ctl_type        md_ctl;
   logic              md_done;
   logic [DATA_W-1:0] md_result;

   assign accept = start && (state_ff == S_IDLE);
   assign c1     = cnt_ff - CW'(1);
   assign c2     = cnt_ff - CW'(2);
   assign c3     = cnt_ff - CW'(3);
   assign cpick  = c2 - tos_ff[CW-1:0];

   // error checks on the incoming command; the divisor and pick index are the top
   always_comb begin
      err = ST_OK;
      if (cnt_ff < CW'(need_of(req_command))) begin
         err = ST_UNDER;
      end else if (grows(req_command) && (cnt_ff == CW'(STACK_DEPTH))) begin
         err = ST_OVER;
      end else if ((req_command == CMD_DIV) && (tos_ff == '0)) begin
         err = ST_DIV0;
      end else if ((req_command == CMD_PICK) && (tos_ff >= DATA_W'(c1))) begin
         err = ST_RANGE;
      end
      no_read = (req_command == CMD_PUSH) || (req_command == CMD_DUP) ||
                (req_command == CMD_NIP) || (req_command > CMD_POP);
      is_rot  = (req_command == CMD_ROT) || (req_command == CMD_NROT);
   end

   assign is_md = (cmd_ff == CMD_MUL) || (cmd_ff == CMD_DIV);

   // binary operators: second entry op top
   always_comb begin
      case (cmd_ff)
         CMD_ADD: alu = a0_ff + tos_ff;
         CMD_SUB: alu = a0_ff - tos_ff;
         CMD_SHL: alu = a0_ff << tos_ff[5:0];
         CMD_SHR: alu = a0_ff >> tos_ff[5:0];
         CMD_EQ:  alu = DATA_W'(a0_ff == tos_ff);
         CMD_NE:  alu = DATA_W'(a0_ff != tos_ff);
         CMD_LT:  alu = DATA_W'(a0_ff < tos_ff);
         CMD_GT:  alu = DATA_W'(a0_ff > tos_ff);
         CMD_LE:  alu = DATA_W'(a0_ff <= tos_ff);
         CMD_GE:  alu = DATA_W'(a0_ff >= tos_ff);
         default: alu = md_result;
      endcase
   end

   // new top, count and write-backs for each stack word
   always_comb begin
      x_tos   = tos_ff;
      x_cnt   = cnt_ff;
      w0_en   = 1'b0;
      w1_en   = 1'b0;
      w0_addr = c2[AW-1:0];
      w1_addr = c2[AW-1:0];
      w0_data = tos_ff;
      w1_data = a0_ff;
      case (cmd_ff) inside
         CMD_PUSH: begin
            w0_en   = (cnt_ff != '0);
            w0_addr = c1[AW-1:0];
            x_tos   = imm_ff;
            x_cnt   = cnt_ff + CW'(1);
         end
         [CMD_ADD:CMD_GE]: begin
            x_tos = alu;
            x_cnt = c1;
         end
         CMD_DUP: begin
            w0_en   = 1'b1;
            w0_addr = c1[AW-1:0];
            x_cnt   = cnt_ff + CW'(1);
         end
         CMD_DROP, CMD_POP: begin
            x_tos = a0_ff;
            x_cnt = c1;
         end
         CMD_SWAP: begin
            w0_en = 1'b1;
            x_tos = a0_ff;
         end
         CMD_NIP: x_cnt = c1;
         CMD_TUCK: begin
            w0_en   = 1'b1;
            w1_en   = 1'b1;
            w1_addr = c1[AW-1:0];
            x_cnt   = cnt_ff + CW'(1);
         end
         CMD_OVER: begin
            w0_en   = 1'b1;
            w0_addr = c1[AW-1:0];
            x_tos   = a0_ff;
            x_cnt   = cnt_ff + CW'(1);
         end
         CMD_ROT: begin
            w0_en   = 1'b1;
            w1_en   = 1'b1;
            w0_addr = c3[AW-1:0];
            w0_data = a1_ff;
            w1_data = tos_ff;
            x_tos   = a0_ff;
         end
         CMD_NROT: begin
            w0_en   = 1'b1;
            w1_en   = 1'b1;
            w0_addr = c3[AW-1:0];
            x_tos   = a1_ff;
         end
         CMD_PICK: x_tos = a0_ff;
         default: x_tos = tos_ff;
      endcase
      if (cmd_ff == CMD_POP) begin
         x_top = tos_ff;
      end else begin
         x_top = (x_cnt != '0) ? x_tos : '0;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      tos_in    = tos_ff;
      md_go_in  = 1'b0;
      status_in = status_ff;
      top_in    = top_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = err;
               top_in    = (cnt_ff != '0) ? tos_ff : '0;
               if (err != ST_OK) begin
                  state_in = S_RESP;
               end else if (no_read) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: state_in = S_RD1;
         S_RD1: begin
            if ((cmd_ff == CMD_ROT) || (cmd_ff == CMD_NROT)) begin
               state_in = S_CAP;
            end else begin
               state_in = S_EXEC;
               md_go_in = is_md;
            end
         end
         S_CAP: state_in = S_EXEC;
         S_EXEC: begin
            if (!is_md || md_done) begin
               cnt_in   = x_cnt;
               tos_in   = x_tos;
               top_in   = x_top;
               state_in = S_WR0;
            end
         end
         S_WR0:  state_in = S_WR1;
         S_WR1:  state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign md_ctl.start  = md_go_ff;
   assign md_ctl.is_div = (cmd_ff == CMD_DIV);

   sma_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .l      (a0_ff),
      .r      (tos_ff),
      .done   (md_done),
      .result (md_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         md_go_ff <= 1'b0;
         w0_en_ff <= 1'b0;
         w1_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         md_go_ff <= md_go_in;
         if (state_ff == S_EXEC) begin
            w0_en_ff <= w0_en;
            w1_en_ff <= w1_en;
         end
      end
      tos_ff    <= tos_in;
      status_ff <= status_in;
      top_ff    <= top_in;
      if (accept) begin
         cmd_ff <= req_command;
         imm_ff <= req_push_value;
         ra0_ff <= is_rot ? c3[AW-1:0] :
                   (req_command == CMD_PICK) ? cpick[AW-1:0] : c2[AW-1:0];
         ra1_ff <= c2[AW-1:0];
      end
      if (state_ff == S_RD1) a0_ff <= rd_ff;
      if (state_ff == S_CAP) a1_ff <= rd_ff;
      if (state_ff == S_EXEC) begin
         w0_addr_ff <= w0_addr;
         w1_addr_ff <= w1_addr;
         w0_data_ff <= w0_data;
         w1_data_ff <= w1_data;
      end
   end

   // stack memory: one write and one registered read a cycle
   assign ra = (state_ff == S_RD1) ? ra1_ff : ra0_ff;
   assign we = ((state_ff == S_WR0) && w0_en_ff) || ((state_ff == S_WR1) && w1_en_ff);
   assign wa = (state_ff == S_WR1) ? w1_addr_ff : w0_addr_ff;
   assign wd = (state_ff == S_WR1) ? w1_data_ff : w0_data_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_RESP);
   assign rsp_status    = status_ff;
   assign rsp_top_value = top_ff;
   assign rsp_depth     = DEPTH_W'(cnt_ff);
endmodule
`default_nettype wire

@@ src/sma_checker.sv @@
`default_nettype none
module sma_checker
   import sma_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [STATUS_W-1:0] rsp_status
);
   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // a transfer in makes the unit busy
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // a result only comes while a command is in flight
   a_resp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   // only defined status codes are reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_RANGE)) else $error("bad status");
endmodule

bind stack_machine_alu sma_checker u_sma_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);
`default_nettype wire

@@ tb/sv/tb_stack_machine_alu.sv @@
`timescale 1ns / 1ps
module tb_stack_machine_alu;
   import sma_pkg::*;

   localparam int STACK_SIZE  = STACK_DEPTH_DEFAULT;
   localparam int RANDOM_CMDS = 600;
   // No transfer in either direction for this long means the block has hung.
   // The slowest command is div, and sender gaps are short.
   localparam int HANG_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 100;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   top_value;
      logic [DEPTH_W-1:0]  depth;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [DATA_W-1:0]   req_push_value;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_top_value;
   logic [DEPTH_W-1:0]  rsp_depth;

   // Shadow copy of the data stack, kept in step with accepted commands.
   logic [DATA_W-1:0] shadow_stack [STACK_SIZE];
   int unsigned       shadow_count;

   outcome_type pending_outcomes [$];
   int unsigned mismatch_count;
   int unsigned hang_cycles;
   bit          quiet_sender;

   stack_machine_alu #(
      .STACK_DEPTH(STACK_SIZE)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_push_value(req_push_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value),
      .rsp_depth(rsp_depth)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Entry i places below the top of the shadow stack.
   function automatic logic [DATA_W-1:0] shadow_at(int unsigned i);
      return shadow_stack[shadow_count - 1 - i];
   endfunction

   // Execute one command on the shadow stack and return what the block
   // should report for it.
   function automatic outcome_type execute_command(logic [CMD_W-1:0] cmd,
                                                   logic [DATA_W-1:0] imm);
      outcome_type       o;
      int unsigned       need;
      bit                grow;
      bit                popped;
      logic [DATA_W-1:0] pop_val, l, r, a, b, c, res;
      need    = 0;
      grow    = 0;
      popped  = 0;
      pop_val = '0;
      o.status = ST_OK;
      if (cmd == CMD_PUSH) grow = 1;
      else if (cmd <= CMD_GE) need = 2;
      else if (cmd == CMD_DUP) begin
         need = 1;
         grow = 1;
      end else if (cmd == CMD_DROP || cmd == CMD_PICK || cmd == CMD_POP) need = 1;
      else if (cmd == CMD_SWAP || cmd == CMD_NIP) need = 2;
      else if (cmd == CMD_TUCK || cmd == CMD_OVER) begin
         need = 2;
         grow = 1;
      end else if (cmd == CMD_ROT || cmd == CMD_NROT) need = 3;

      if (shadow_count < need) begin
         o.status = ST_UNDER;
         // a failed pop reports zero rather than the top
         if (cmd == CMD_POP) popped = 1;
      end else if (grow && shadow_count >= STACK_SIZE) begin
         o.status = ST_OVER;
      end else if (cmd == CMD_PUSH) begin
         shadow_stack[shadow_count] = imm;
         shadow_count++;
      end else if (cmd <= CMD_GE) begin
         l = shadow_at(1);
         r = shadow_at(0);
         if (cmd == CMD_DIV && r == '0) begin
            o.status = ST_DIV0;
         end else begin
            case (cmd)
               CMD_ADD: res = l + r;
               CMD_SUB: res = l - r;
               CMD_MUL: res = l * r;
               CMD_DIV: res = l / r;
               CMD_SHL: res = l << r[5:0];
               CMD_SHR: res = l >> r[5:0];
               CMD_EQ:  res = DATA_W'(l == r);
               CMD_NE:  res = DATA_W'(l != r);
               CMD_LT:  res = DATA_W'(l < r);
               CMD_GT:  res = DATA_W'(l > r);
               CMD_LE:  res = DATA_W'(l <= r);
               default: res = DATA_W'(l >= r);
            endcase
            shadow_count--;
            shadow_stack[shadow_count - 1] = res;
         end
      end else begin
         case (cmd)
            CMD_DUP: begin
               shadow_stack[shadow_count] = shadow_at(0);
               shadow_count++;
            end
            CMD_DROP: shadow_count--;
            CMD_SWAP: begin
               a = shadow_at(0);
               shadow_stack[shadow_count - 1] = shadow_at(1);
               shadow_stack[shadow_count - 2] = a;
            end
            CMD_NIP: begin
               a = shadow_at(0);
               shadow_count--;
               shadow_stack[shadow_count - 1] = a;
            end
            CMD_TUCK: begin
               b = shadow_at(0);
               a = shadow_at(1);
               shadow_count++;
               shadow_stack[shadow_count - 3] = b;
               shadow_stack[shadow_count - 2] = a;
               shadow_stack[shadow_count - 1] = b;
            end
            CMD_OVER: begin
               shadow_stack[shadow_count] = shadow_at(1);
               shadow_count++;
            end
            CMD_ROT: begin
               a = shadow_at(2);
               b = shadow_at(1);
               c = shadow_at(0);
               shadow_stack[shadow_count - 3] = b;
               shadow_stack[shadow_count - 2] = c;
               shadow_stack[shadow_count - 1] = a;
            end
            CMD_NROT: begin
               a = shadow_at(2);
               b = shadow_at(1);
               c = shadow_at(0);
               shadow_stack[shadow_count - 3] = c;
               shadow_stack[shadow_count - 2] = a;
               shadow_stack[shadow_count - 1] = b;
            end
            CMD_PICK: begin
               // the index sits on top; zero names the entry just under it
               a = shadow_at(0);
               if (a >= DATA_W'(shadow_count - 1)) o.status = ST_RANGE;
               else shadow_stack[shadow_count - 1] = shadow_at(int'(a) + 1);
            end
            CMD_POP: begin
               popped  = 1;
               pop_val = shadow_at(0);
               shadow_count--;
            end
            default: ; // unused codes leave everything alone
         endcase
      end

      if (popped) o.top_value = pop_val;
      else o.top_value = (shadow_count != 0) ? shadow_at(0) : '0;
      o.depth = DEPTH_W'(shadow_count);
      return o;
   endfunction

   // Present one command and hold it until the block takes it.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] imm);
      bit was_busy;
      int gap;
      @(negedge clock);
      // idle the request side now and then, except in the quiet stretch
      if (!quiet_sender && $urandom_range(99) < 10) begin
         start <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_push_value <= imm;
      forever begin
         // busy only moves on a rising edge, so its value here holds to the next one
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
         @(negedge clock);
      end
      pending_outcomes.push_back(execute_command(cmd, imm));
   endtask

   task automatic go_idle;
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_word;
      return {$urandom, $urandom};
   endfunction

   task automatic push_word(logic [DATA_W-1:0] v);
      send_command(CMD_PUSH, v);
   endtask

   task automatic drain_stack;
      while (shadow_count != 0) send_command(CMD_DROP, random_word());
   endtask

   // Every primitive on an empty stack underflows; unused codes are no-ops.
   task automatic test_empty_stack;
      logic [CMD_W-1:0] cmd;
      for (int i = 1; i < 32; i++) begin
         cmd = CMD_W'(i);
         send_command(cmd, random_word());
      end
   endtask

   task automatic test_arithmetic;
      logic [CMD_W-1:0] cmd;
      push_word('1);
      push_word('0);
      send_command(CMD_DIV, '0);     // divide by zero leaves both entries
      drain_stack();
      for (int i = CMD_ADD; i <= CMD_GE; i++) begin
         cmd = CMD_W'(i);
         push_word('1);
         push_word((i % 2) ? 64'd1 : 64'h8000_0000_0000_0000);
         send_command(cmd, '1);
         drain_stack();
      end
      // shift amounts wrap at 64
      push_word(64'h0123_4567_89ab_cdef);
      push_word(64'd64);
      send_command(CMD_SHL, '0);
      push_word(64'd63);
      send_command(CMD_SHR, '0);
      drain_stack();
   endtask

   task automatic test_stack_words;
      push_word(64'd11);
      send_command(CMD_PICK, '0);    // nothing below the index
      push_word(64'd22);
      push_word(64'd33);
      send_command(CMD_ROT, '0);
      send_command(CMD_NROT, '0);
      send_command(CMD_SWAP, '0);
      send_command(CMD_TUCK, '0);
      send_command(CMD_OVER, '0);
      send_command(CMD_NIP, '0);
      send_command(CMD_DUP, '0);
      push_word(64'd2);
      send_command(CMD_PICK, '0);
      push_word(64'd5);
      send_command(CMD_PICK, '0);    // index names the bottom entry, the deepest legal pick
      push_word('1);
      send_command(CMD_PICK, '0);
      send_command(CMD_POP, '0);
      drain_stack();
      send_command(CMD_POP, '0);
   endtask

   // Fill to the last entry, then every growing command must overflow.
   task automatic test_full_stack;
      while (shadow_count < STACK_SIZE) push_word(random_word());
      push_word('1);
      send_command(CMD_DUP, '0);
      send_command(CMD_TUCK, '0);
      send_command(CMD_OVER, '0);
      push_word(64'd254);
      send_command(CMD_DROP, '0);
      push_word(64'd254);
      send_command(CMD_PICK, '0);    // deepest legal pick
      drain_stack();
   endtask

   // Mostly well-formed programs over a shallow stack, with some noise.
   task automatic test_random_programs;
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] imm;
      int unsigned       sel;
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         if (i == RANDOM_CMDS / 3) quiet_sender = 1'b1;
         if (i == RANDOM_CMDS / 2) quiet_sender = 1'b0;
         sel = $urandom_range(99);
         if (sel < 5) imm = random_word();
         else if (sel < 10) imm = '1;
         else imm = (sel < 60) ? 64'($urandom_range(8)) : random_word();
         sel = $urandom_range(99);
         if (sel < 3) cmd = CMD_W'($urandom_range(31));   // any code at all
         else if (shadow_count < 3 || sel < 35) cmd = CMD_PUSH;
         else if (shadow_count > 24 && sel < 60) cmd = CMD_DROP;
         else cmd = CMD_W'($urandom_range(CMD_POP, CMD_ADD));
         send_command(cmd, imm);
      end
   endtask

   // Compare each strobed result with the oldest outstanding expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d top %h depth %0d",
                        rsp_status, rsp_top_value, rsp_depth);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_top_value !== want.top_value
                || rsp_depth !== want.depth) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d top %h depth %0d, got %0d %h %0d",
                           want.status, want.top_value, want.depth,
                           rsp_status, rsp_top_value, rsp_depth);
            end
         end
      end
   end

   // Hang detection: advance while neither side transfers anything.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) hang_cycles <= 0;
      else hang_cycles <= hang_cycles + 1;
      if (hang_cycles > HANG_LIMIT) begin
         $display("stack_machine_alu regression: fail");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_PUSH;
      req_push_value = '0;
      shadow_count   = 0;
      mismatch_count = 0;
      hang_cycles    = 0;
      quiet_sender   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_stack();
      test_arithmetic();
      test_stack_words();
      test_full_stack();
      test_random_programs();
      go_idle();

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("stack_machine_alu regression: pass");
      end else begin
         $display("stack_machine_alu regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sma_pkg.sv
src/sma_muldiv.sv
src/stack_machine_alu.sv
src/sma_checker.sv
tb/sv/tb_stack_machine_alu.sv
